>>> design/tpsp_pkg.sv
// Package for the typed packet stream parser: result codes, phase enum,
// type name table and the front-to-back queue entry. No dependencies.
`default_nettype none
package tpsp_pkg;

    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    localparam logic [1:0] KIND_BODY     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_BAD_TYPE = 2'd2;
    localparam logic [1:0] KIND_BAD_EOL  = 2'd3;

    localparam int NUM_TYPES  = 22;
    localparam int PREFIX_LEN = 15;

    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  ptype;
        logic [7:0]  data;
        logic [23:0] blen;
        logic        last;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic logic [23:0] type_name(input logic [4:0] i);
        case (i)
            5'd0:    type_name = "hbt";
            5'd1:    type_name = "lgn";
            5'd2:    type_name = "rgt";
            5'd3:    type_name = "lgt";
            5'd4:    type_name = "scu";
            5'd5:    type_name = "adf";
            5'd6:    type_name = "def";
            5'd7:    type_name = "rfr";
            5'd8:    type_name = "rcn";
            5'd9:    type_name = "gfi";
            5'd10:   type_name = "afi";
            5'd11:   type_name = "dfi";
            5'd12:   type_name = "sma";
            5'd13:   type_name = "rma";
            5'd14:   type_name = "rdy";
            5'd15:   type_name = "sav";
            5'd16:   type_name = "rav";
            5'd17:   type_name = "soc";
            5'd18:   type_name = "roc";
            5'd19:   type_name = "aoc";
            5'd20:   type_name = "doc";
            5'd21:   type_name = "eoc";
            default: type_name = 24'd0;
        endcase
    endfunction

    function automatic logic [7:0] prefix_char(input logic [3:0] i);
        case (i)
            4'd0:    prefix_char = "c";
            4'd1:    prefix_char = "o";
            4'd2:    prefix_char = "n";
            4'd3:    prefix_char = "t";
            4'd4:    prefix_char = "e";
            4'd5:    prefix_char = "n";
            4'd6:    prefix_char = "t";
            4'd7:    prefix_char = "-";
            4'd8:    prefix_char = "l";
            4'd9:    prefix_char = "e";
            4'd10:   prefix_char = "n";
            4'd11:   prefix_char = "g";
            4'd12:   prefix_char = "t";
            4'd13:   prefix_char = "h";
            4'd14:   prefix_char = ":";
            default: prefix_char = 8'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> design/tpsp_front.sv
// Front part: parses each accepted byte and produces at most one result item.
// Depends on tpsp_pkg.
`default_nettype none
module tpsp_front #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       in_byte,
    output tpsp_pkg::result_t     res,
    output logic                  res_valid
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    tpsp_pkg::phase_t         phase_reg, phase_next;
    logic                     cr_reg, cr_next;
    logic [7:0]               t0_reg, t1_reg, t2_reg, t0_next, t1_next, t2_next;
    logic [4:0]               pos_reg, pos_next;
    logic                     pm_reg, pm_next;
    logic [1:0]               np_reg, np_next;
    logic [4:0]               kind_reg, kind_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [LENGTH_BITS-1:0]   cnt_reg, cnt_next;

    // Decimal accumulate with saturation.
    logic [LENGTH_BITS+4:0]   acc;
    logic [LENGTH_BITS-1:0]   acc_sat;
    logic                     is_digit;
    assign is_digit = in_byte >= 8'h30 && in_byte <= 8'h39;
    assign acc = {5'd0, len_reg} * (LENGTH_BITS+5)'(10)
               + (LENGTH_BITS+5)'(in_byte - 8'h30);
    assign acc_sat = (acc > {5'd0, LEN_MAX}) ? LEN_MAX : acc[LENGTH_BITS-1:0];

    // Type name lookup over the constant table.
    logic       type_hit;
    logic [4:0] type_idx;
    always_comb
    begin
        type_hit = 1'b0;
        type_idx = 5'd0;
        for (int i = tpsp_pkg::NUM_TYPES - 1; i >= 0; i--)
        begin
            if ({tpsp_pkg::to_lower(t0_reg), tpsp_pkg::to_lower(t1_reg),
                 tpsp_pkg::to_lower(t2_reg)} == tpsp_pkg::type_name(5'(i)))
            begin
                type_hit = 1'b1;
                type_idx = 5'(i);
            end
        end
    end

    logic [LENGTH_BITS-1:0] cnt_inc;
    assign cnt_inc = cnt_reg + 1'b1;

    // Per-byte parse step.
    always_comb
    begin
        phase_next = phase_reg;
        cr_next = cr_reg;
        t0_next = t0_reg; t1_next = t1_reg; t2_next = t2_reg;
        pos_next = pos_reg;
        pm_next = pm_reg;
        np_next = np_reg;
        kind_next = kind_reg;
        len_next = len_reg;
        cnt_next = cnt_reg;
        res_valid = 1'b0;
        res = '0;
        if (step)
        begin
            if (phase_reg == tpsp_pkg::PH_BODY)
            begin
                res_valid = 1'b1;
                res.kind = tpsp_pkg::KIND_BODY;
                res.ptype = kind_reg;
                res.data = in_byte;
                res.blen = 24'(len_reg);
                res.last = cnt_inc >= len_reg;
                cnt_next = cnt_inc;
                if (res.last)
                begin
                    phase_next = tpsp_pkg::PH_TYPE;
                    kind_next = '0; len_next = '0; cnt_next = '0;
                    cr_next = 1'b0; pos_next = '0; pm_next = 1'b1; np_next = '0;
                    t0_next = '0; t1_next = '0; t2_next = '0;
                end
            end
            else if (cr_reg || in_byte == tpsp_pkg::CH_LF)
            begin
                // Line end: new line state in every case.
                cr_next = 1'b0; pos_next = '0; pm_next = 1'b1; np_next = '0;
                t0_next = '0; t1_next = '0; t2_next = '0;
                if (!cr_reg || in_byte != tpsp_pkg::CH_LF)
                begin
                    res_valid = 1'b1;
                    res.kind = tpsp_pkg::KIND_BAD_EOL;
                    phase_next = tpsp_pkg::PH_TYPE;
                    kind_next = '0; len_next = '0; cnt_next = '0;
                end
                else if (phase_reg == tpsp_pkg::PH_TYPE)
                begin
                    if (pos_reg == 5'd3 && type_hit)
                    begin
                        kind_next = type_idx;
                        phase_next = tpsp_pkg::PH_HEADER;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res.kind = tpsp_pkg::KIND_BAD_TYPE;
                        kind_next = '0; len_next = '0; cnt_next = '0;
                    end
                end
                else if (pos_reg == 5'd0)
                begin
                    if (len_reg != '0)
                    begin
                        phase_next = tpsp_pkg::PH_BODY;
                        cnt_next = '0;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res.kind = tpsp_pkg::KIND_COMPLETE;
                        res.ptype = kind_reg;
                        phase_next = tpsp_pkg::PH_TYPE;
                        kind_next = '0; len_next = '0; cnt_next = '0;
                    end
                end
            end
            else if (in_byte == tpsp_pkg::CH_CR)
            begin
                cr_next = 1'b1;
            end
            else
            begin
                // Ordinary line byte.
                if (phase_reg == tpsp_pkg::PH_TYPE)
                begin
                    if (pos_reg == 5'd0) t0_next = in_byte;
                    if (pos_reg == 5'd1) t1_next = in_byte;
                    if (pos_reg == 5'd2) t2_next = in_byte;
                end
                else if (pos_reg < 5'(tpsp_pkg::PREFIX_LEN))
                begin
                    if (tpsp_pkg::to_lower(in_byte) != tpsp_pkg::prefix_char(pos_reg[3:0]))
                        pm_next = 1'b0;
                    if (pos_reg == 5'(tpsp_pkg::PREFIX_LEN - 1) && pm_next)
                    begin
                        len_next = '0;
                        np_next = '0;
                    end
                end
                else if (pm_reg)
                begin
                    if (np_reg == 2'd0 &&
                        (in_byte == tpsp_pkg::CH_SP || in_byte == tpsp_pkg::CH_TAB))
                        np_next = np_reg;
                    else if (np_reg != 2'd2 && is_digit)
                    begin
                        len_next = acc_sat;
                        np_next = 2'd1;
                    end
                    else
                        np_next = 2'd2;
                end
                if (pos_reg != 5'd31)
                    pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tpsp_pkg::PH_TYPE;
            cr_reg <= 1'b0;
            t0_reg <= '0; t1_reg <= '0; t2_reg <= '0;
            pos_reg <= '0;
            pm_reg <= 1'b1;
            np_reg <= '0;
            kind_reg <= '0;
            len_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cr_reg <= cr_next;
            t0_reg <= t0_next; t1_reg <= t1_next; t2_reg <= t2_next;
            pos_reg <= pos_next;
            pm_reg <= pm_next;
            np_reg <= np_next;
            kind_reg <= kind_next;
            len_reg <= len_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> design/tpsp_queue.sv
// Two-entry result queue between the front parser and the output port.
// Depends on tpsp_pkg.
`default_nettype none
module tpsp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tpsp_pkg::result_t push_data,
    output logic                   full,
    output logic                   pop_valid,
    input  wire logic              pop,
    output tpsp_pkg::result_t      pop_data
);

    tpsp_pkg::result_t mem_reg [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;

    assign full = cnt_reg == 2'd2;
    assign pop_valid = cnt_reg != 2'd0;
    assign pop_data = mem_reg[rp_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

>>> design/typed_packet_stream_parser.sv
// Top level of the typed packet stream parser: front parser plus result queue.
// Depends on tpsp_pkg, tpsp_front and tpsp_queue.
//
//  channel | signals                                              | dir
//  input   | in_valid, in_ready, in_byte                          | in
//  output  | out_valid, out_ready, result_kind, type_code,        | out
//          | data_byte, body_length, last_byte                    |
//
// One byte is accepted per cycle while the queue is not full; its result
// item, if any, is available from the queue in the following cycle. The
// two-entry queue sets the stall depth: input is held off only while both
// entries wait. Reset returns the parser to the type line with an empty queue.
`default_nettype none
module typed_packet_stream_parser #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [4:0]       type_code,
    output logic [7:0]       data_byte,
    output logic [23:0]      body_length,
    output logic             last_byte
);

    tpsp_pkg::result_t res, head;
    logic res_valid, full, step, pop;

    assign in_ready = !full;
    assign step = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    tpsp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .step(step), .in_byte(in_byte),
        .res(res), .res_valid(res_valid)
    );

    tpsp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(res_valid), .push_data(res),
        .full(full), .pop_valid(out_valid), .pop(pop), .pop_data(head)
    );

    assign result_kind = head.kind;
    assign type_code   = head.ptype;
    assign data_byte   = head.data;
    assign body_length = head.blen;
    assign last_byte   = head.last;

    // Results only arise from accepted bytes.
    a_res_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> step) else $error("result without accepted item");

    // Error items carry no type.
    a_err_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind[1] |-> type_code == 5'd0)
        else $error("error item with type");

    // Input stalls only while queue is full.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid) else $error("stall with empty queue");

endmodule
`default_nettype wire
